>>> hdl/pbtp_pkg.sv
// ----------------------------------------------------------------------------
// pbtp_pkg
// Shared constants for the bilevel threshold packer: pixel format codes,
// register indexes, channel weights and word geometry.
// ----------------------------------------------------------------------------
package pbtp_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned CountBits = 5;
  localparam int unsigned FmtBits   = 2;
  localparam int unsigned ThrBits   = 9;
  localparam int unsigned CfgAddrBits = 1;
  localparam int unsigned CfgDataBits = ThrBits;

  // Gray sum width: 255 * (11 + 16 + 5) = 8160 fits in 13 bits.
  localparam int unsigned SumBits   = 13;
  // Threshold times 32.
  localparam int unsigned LimitBits = ThrBits + 5;
  // Alpha times threshold times 32, and gray sum times 255.
  localparam int unsigned PmBits    = LimitBits + 8;

  localparam logic [SumBits-1:0] WeightR = 13'd11;
  localparam logic [SumBits-1:0] WeightG = 13'd16;
  localparam logic [SumBits-1:0] WeightB = 13'd5;

  localparam logic [FmtBits-1:0] FMT_RGB32   = 2'd0;
  localparam logic [FmtBits-1:0] FMT_PREMUL  = 2'd1;
  localparam logic [FmtBits-1:0] FMT_RGB565  = 2'd2;

  localparam logic [CfgAddrBits-1:0] REG_PIXEL_FORMAT   = 1'd0;
  localparam logic [CfgAddrBits-1:0] REG_GRAY_THRESHOLD = 1'd1;

  localparam logic [ThrBits-1:0] ThrReset = 9'd128;

endpackage

>>> hdl/pixel_bilevel_threshold_packer_core.sv
// ----------------------------------------------------------------------------
// pixel_bilevel_threshold_packer_core
// Binarizes a pixel stream by weighted gray threshold and packs the bits,
// first pixel in the MSB, into 32-bit words per line.
// ----------------------------------------------------------------------------
// One pixel is taken every clock. A pixel passes an input register, is
// classified and merged into the bit accumulator, and a finished word lands
// in the output register. A word leaves when 32 pixels are gathered or when a
// pixel with tlast set ends the line; a short word has its unused low bits at
// zero and carries tlast. Throughput stays at one pixel per clock as long as
// the word side takes each word; a stall on out_tready backs up into in_tready
// only when the next pixel would emit a word. Configuration must be written
// only while the stream is idle, by the user; the block does not enforce it.
module pixel_bilevel_threshold_packer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pbtp_pkg::WordBits-1:0]      in_tdata,   // [31:0] pixel_value
  input  logic                               in_tlast,   // line_end
  // packed word stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pbtp_pkg::WordBits-1:0]      out_tdata,  // [31:0] packed_word
  output logic                               out_tlast,  // line_last_word
  // configuration
  input  logic                               cfg_we,
  input  logic [pbtp_pkg::CfgAddrBits-1:0]   cfg_addr,
  input  logic [pbtp_pkg::CfgDataBits-1:0]   cfg_wdata
);

  logic [pbtp_pkg::FmtBits-1:0]   fmt_r;
  logic [pbtp_pkg::ThrBits-1:0]   thr_r;

  logic                           s1_valid_r;
  logic [pbtp_pkg::WordBits-1:0]  s1_pixel_r;
  logic                           s1_last_r;

  logic [pbtp_pkg::WordBits-1:0]  acc_r, acc_nxt;
  logic [pbtp_pkg::CountBits-1:0] bit_count_r, bit_count_nxt;

  logic                           out_valid_r;
  logic [pbtp_pkg::WordBits-1:0]  out_data_r;
  logic                           out_last_r;

  logic                           black;
  logic                           emit;
  logic                           out_free;
  logic                           s1_consume;
  logic                           in_fire;
  logic [pbtp_pkg::WordBits-1:0]  acc_set;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= pbtp_pkg::FMT_RGB32;
      thr_r <= pbtp_pkg::ThrReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pbtp_pkg::REG_PIXEL_FORMAT:   fmt_r <= cfg_wdata[pbtp_pkg::FmtBits-1:0];
        pbtp_pkg::REG_GRAY_THRESHOLD: thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pbtp_classify u_classify (
    .pixel          (s1_pixel_r),
    .pixel_format   (fmt_r),
    .gray_threshold (thr_r),
    .black          (black)
  );

  assign emit       = (bit_count_r == '1) || s1_last_r;
  assign out_free   = !out_valid_r || out_tready;
  // a pixel that closes a word needs the output slot
  assign s1_consume = s1_valid_r && (!emit || out_free);
  assign in_tready  = !s1_valid_r || s1_consume;
  assign in_fire    = in_tvalid && in_tready;

  always_comb begin
    acc_set = acc_r;
    // bit position 31 - count is the bitwise complement of count
    acc_set[~bit_count_r] = black;
    acc_nxt       = acc_r;
    bit_count_nxt = bit_count_r;
    if (s1_consume) begin
      if (emit) begin
        acc_nxt       = '0;
        bit_count_nxt = '0;
      end else begin
        acc_nxt       = acc_set;
        bit_count_nxt = bit_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      bit_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_consume) begin
        s1_valid_r <= 1'b0;
      end
      acc_r       <= acc_nxt;
      bit_count_r <= bit_count_nxt;
      if (s1_consume && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel_r <= in_tdata;
      s1_last_r  <= in_tlast;
    end
    if (s1_consume && emit) begin
      out_data_r <= acc_set;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // bits not yet filled in the accumulator stay zero
  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r << bit_count_r) == '0)
    else $error("accumulator holds bits beyond the current position");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_consume && !emit |=> bit_count_r == $past(bit_count_r) + 1'b1)
    else $error("bit count did not advance by one");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_consume && emit |=> out_valid_r && bit_count_r == '0)
    else $error("emitted word not staged or count not cleared");

endmodule

>>> hdl/pbtp_classify.sv
// ----------------------------------------------------------------------------
// pbtp_classify
// Reduces one pixel to a bilevel bit: weighted gray sum compared against the
// scaled threshold, with premultiplied alpha and RGB565 widening.
// ----------------------------------------------------------------------------
module pbtp_classify (
  input  logic [pbtp_pkg::WordBits-1:0] pixel,
  input  logic [pbtp_pkg::FmtBits-1:0]  pixel_format,
  input  logic [pbtp_pkg::ThrBits-1:0]  gray_threshold,
  output logic                          black
);

  logic [7:0]                        a8, r8, g8, b8;
  logic [15:0]                       c565;
  logic [pbtp_pkg::SumBits-1:0]      gray_sum;
  logic [pbtp_pkg::LimitBits-1:0]    limit;
  logic [pbtp_pkg::ThrBits+7:0]      alpha_thr;
  logic [pbtp_pkg::PmBits-1:0]       alpha_limit;
  logic [pbtp_pkg::PmBits-1:0]       sum_x255;

  assign c565 = pixel[15:0];
  assign a8   = pixel[31:24];

  always_comb begin
    if (pixel_format == pbtp_pkg::FMT_RGB565) begin
      // widen by replicating the top bits of each channel
      r8 = {c565[15:11], c565[15:13]};
      g8 = {c565[10:5],  c565[10:9]};
      b8 = {c565[4:0],   c565[4:2]};
    end else begin
      r8 = pixel[23:16];
      g8 = pixel[15:8];
      b8 = pixel[7:0];
    end
  end

  assign gray_sum = {5'd0, r8} * pbtp_pkg::WeightR
                  + {5'd0, g8} * pbtp_pkg::WeightG
                  + {5'd0, b8} * pbtp_pkg::WeightB;

  assign limit       = {gray_threshold, 5'd0};
  assign alpha_thr   = {8'd0, gray_threshold} * {9'd0, a8};
  assign alpha_limit = {alpha_thr, 5'd0};
  // sum * 255 = sum * 256 - sum
  assign sum_x255    = {1'b0, gray_sum, 8'd0} - {9'd0, gray_sum};

  always_comb begin
    unique case (pixel_format)
      pbtp_pkg::FMT_PREMUL: black = (a8 == 8'd0) || (sum_x255 < alpha_limit);
      default:              black = ({1'b0, gray_sum} < limit);
    endcase
  end

endmodule
